### rtl/rcem_pkg.sv
// ----------------------------------------------------------------------------
// rcem_pkg: shared constants for the Roberts cross edge magnitude unit
// Field widths, register indexes, command codes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package rcem_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int SQ_W    = 17;

    // 255 squared: scale of the normalized square magnitude
    localparam logic [15:0] DIV_SCALE = 16'd65025;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE    = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

endpackage

`default_nettype wire

### rtl/roberts_cross_edge_magnitude_unit.sv
// ----------------------------------------------------------------------------
// roberts_cross_edge_magnitude_unit: frame buffered Roberts cross edge filter
// Loads a grayscale frame, finds its largest square gradient, then drains one
// edge magnitude per request in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries command and pixel. A load
//   command writes the pixel into the frame memory. After the final pixel
//   of the frame the unit sweeps the whole frame to find the largest square
//   magnitude (per pixel 4 memory reads through the single read port, a
//   capture step and the square/compare step); no transfer is taken meanwhile.
//   A drain command reads and squares the four neighbors, then in raw mode
//   runs a 9 step square root, in normalize mode a multiply, a 16 step
//   division and the square root (the root of zero if the maximum is zero).
//   No new transfer is taken until the item's result is registered; the
//   single read port and the shared divide/root sequencer set the pace.
//   A drain before the frame is complete gives a not_ready result at once.
//   Output channel (out_valid/out_ready) holds one result in a register; a
//   load transfer is still taken while that result waits, a drain waits
//   for the slot to free. Reset clears counters, the frame maximum and the
//   configuration (256 x 256, raw mode); the frame memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module roberts_cross_edge_magnitude_unit #(
    parameter int MAX_WIDTH  = rcem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rcem_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           command,
    input  wire logic [rcem_pkg::PIX_W-1:0]     pixel,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [rcem_pkg::PIX_W-1:0]     edge_value,
    output logic                                last,
    output logic                                not_ready,
    input  wire logic                           cfg_we,
    input  wire logic [rcem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rcem_pkg::CFG_W-1:0]     cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int PW    = rcem_pkg::PIX_W;
    localparam int SW    = rcem_pkg::SQ_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_SQUARE = 6'b000100,
        ST_SCALE  = 6'b001000,
        ST_DIVIDE = 6'b010000,
        ST_ROOT   = 6'b100000
    } state_t;

    // control state
    state_t                  state_reg, state_next;
    logic [2:0]              phase_reg, phase_next;
    logic [3:0]              iter_reg, iter_next;
    logic                    sweep_reg, sweep_next;
    logic [CNTW-1:0]         load_reg, load_next;
    logic [XW-1:0]           x_reg, x_next;
    logic [YW-1:0]           y_reg, y_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [SW-1:0]           max_reg, max_next;
    logic [rcem_pkg::CFG_W-1:0] width_reg, width_next;
    logic [rcem_pkg::CFG_W-1:0] height_reg, height_next;
    logic                    norm_reg, norm_next;
    logic                    out_valid_reg, out_valid_next;

    // datapath
    logic [PW-1:0]           p_reg [4];
    logic [PW-1:0]           p_next [4];
    logic [SW-1:0]           s_reg, s_next;
    logic [SW-1:0]           rem_reg, rem_next;
    logic [15:0]             quo_reg, quo_next;
    logic [17:0]             v_reg, v_next;
    logic [8:0]              root_reg, root_next;
    logic [11:0]             rrem_reg, rrem_next;
    logic [PW-1:0]           edge_reg, edge_next;
    logic                    last_reg, last_next;
    logic                    nrdy_reg, nrdy_next;

    logic [WW-1:0]           eff_w;
    logic [HW-1:0]           eff_h;
    logic [CNTW-1:0]         total;
    logic                    x_last, y_last, frame_last;
    logic [31:0]             dx, dyw;
    logic [AW-1:0]           a00, a11, a10, a01;
    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_raddr;
    logic [PW-1:0]           mem_rdata;
    logic                    accept;
    logic                    loaded;

    logic signed [9:0]       gx, gy;
    logic signed [19:0]      gx2, gy2;
    logic [19:0]             sq;
    logic [32:0]             prod;
    logic [17:0]             rem_sh;
    logic                    div_ge;
    logic [13:0]             rt_rem, rt_trial;
    logic                    rt_ge;
    logic [8:0]              rt_root;

    // clamp the configured size into 1..MAX
    always_comb
    begin
        if (width_reg == '0)
            eff_w = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(width_reg);
        if (height_reg == '0)
            eff_h = HW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(height_reg);
    end

    assign total      = CNTW'(32'(eff_w) * 32'(eff_h));
    assign loaded     = (load_reg == total);
    assign x_last     = (32'(x_reg) + 32'd1 == 32'(eff_w));
    assign y_last     = (32'(y_reg) + 32'd1 == 32'(eff_h));
    assign frame_last = x_last && y_last;

    // neighbor addresses, right and bottom clamped at the border
    assign dx  = x_last ? 32'd0 : 32'd1;
    assign dyw = y_last ? 32'd0 : 32'(eff_w);
    assign a00 = idx_reg;
    assign a11 = AW'(32'(idx_reg) + dx + dyw);
    assign a10 = AW'(32'(idx_reg) + dx);
    assign a01 = AW'(32'(idx_reg) + dyw);

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE)
                    && (!out_valid_reg || out_ready || command == rcem_pkg::CMD_LOAD);
    assign mem_we    = accept && command == rcem_pkg::CMD_LOAD && !loaded;
    assign mem_re    = (state_reg == ST_READ) && (phase_reg < 3'd4);

    always_comb
    begin
        case (phase_reg)
            3'd0:    mem_raddr = a00;
            3'd1:    mem_raddr = a11;
            3'd2:    mem_raddr = a10;
            default: mem_raddr = a01;
        endcase
    end

    rcem_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (load_reg[AW-1:0]),
        .wdata (pixel),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // square gradient from the four captured neighbors
    assign gx  = $signed({2'b00, p_reg[0]}) - $signed({2'b00, p_reg[1]});
    assign gy  = $signed({2'b00, p_reg[2]}) - $signed({2'b00, p_reg[3]});
    assign gx2 = gx * gx;
    assign gy2 = gy * gy;
    assign sq  = 20'(gx2) + 20'(gy2);

    assign prod = 33'(rcem_pkg::DIV_SCALE) * 33'(s_reg);

    // one restoring division step
    assign rem_sh = {rem_reg, quo_reg[15]};
    assign div_ge = rem_sh >= {1'b0, max_reg};

    // one square root step
    assign rt_rem   = {rrem_reg, v_reg[17:16]};
    assign rt_trial = {3'b000, root_reg, 2'b01};
    assign rt_ge    = rt_rem >= rt_trial;
    assign rt_root  = {root_reg[7:0], rt_ge};

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        iter_next      = iter_reg;
        sweep_next     = sweep_reg;
        load_next      = load_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        idx_next       = idx_reg;
        max_next       = max_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        norm_next      = norm_reg;
        out_valid_next = out_valid_reg;
        p_next         = p_reg;
        s_next         = s_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        v_next         = v_reg;
        root_next      = root_reg;
        rrem_next      = rrem_reg;
        edge_next      = edge_reg;
        last_next      = last_reg;
        nrdy_next      = nrdy_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == rcem_pkg::CMD_LOAD)
                    begin
                        if (!loaded)
                        begin
                            load_next = load_reg + CNTW'(1);
                            if (load_reg + CNTW'(1) == total)
                            begin
                                // frame complete: sweep for the maximum
                                sweep_next = 1'b1;
                                phase_next = 3'd0;
                                state_next = ST_READ;
                            end
                        end
                    end
                    else if (!loaded)
                    begin
                        edge_next      = '0;
                        last_next      = 1'b0;
                        nrdy_next      = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        sweep_next = 1'b0;
                        phase_next = 3'd0;
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                if (phase_reg != 3'd0)
                    p_next[phase_reg[1:0] - 2'd1] = mem_rdata;
                if (phase_reg == 3'd4)
                    state_next = ST_SQUARE;
                else
                    phase_next = phase_reg + 3'd1;
            end

            ST_SQUARE:
            begin
                s_next = sq[SW-1:0];
                if (sweep_reg)
                begin
                    if (sq[SW-1:0] > max_reg)
                        max_next = sq[SW-1:0];
                    phase_next = 3'd0;
                    if (frame_last)
                    begin
                        x_next     = '0;
                        y_next     = '0;
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        x_next     = x_last ? '0 : x_reg + XW'(1);
                        y_next     = x_last ? y_reg + YW'(1) : y_reg;
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_READ;
                    end
                end
                else if (norm_reg && max_reg == '0)
                begin
                    root_next  = '0;
                    state_next = ST_ROOT;
                    v_next     = '0;
                    rrem_next  = '0;
                    iter_next  = 4'd8;
                end
                else if (norm_reg)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    v_next     = 18'(sq[SW-1:0]);
                    root_next  = '0;
                    rrem_next  = '0;
                    iter_next  = 4'd8;
                    state_next = ST_ROOT;
                end
            end

            ST_SCALE:
            begin
                // quotient fits 16 bits since s never exceeds the maximum
                rem_next   = prod[32:16];
                quo_next   = prod[15:0];
                iter_next  = 4'd15;
                state_next = ST_DIVIDE;
            end

            ST_DIVIDE:
            begin
                rem_next = div_ge ? SW'(rem_sh - {1'b0, max_reg}) : rem_sh[SW-1:0];
                quo_next = {quo_reg[14:0], div_ge};
                if (iter_reg == 4'd0)
                begin
                    v_next     = {2'b00, quo_reg[14:0], div_ge};
                    root_next  = '0;
                    rrem_next  = '0;
                    iter_next  = 4'd8;
                    state_next = ST_ROOT;
                end
                else
                    iter_next = iter_reg - 4'd1;
            end

            ST_ROOT:
            begin
                rrem_next = rt_ge ? 12'(rt_rem - rt_trial) : rt_rem[11:0];
                root_next = rt_root;
                v_next    = {v_reg[15:0], 2'b00};
                if (iter_reg == 4'd0)
                begin
                    // deliver and advance to the next pixel
                    edge_next      = rt_root[8] ? 8'hFF : rt_root[7:0];
                    last_next      = frame_last;
                    nrdy_next      = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (frame_last)
                    begin
                        load_next = '0;
                        max_next  = '0;
                        x_next    = '0;
                        y_next    = '0;
                        idx_next  = '0;
                    end
                    else
                    begin
                        x_next   = x_last ? '0 : x_reg + XW'(1);
                        y_next   = x_last ? y_reg + YW'(1) : y_reg;
                        idx_next = idx_reg + AW'(1);
                    end
                end
                else
                    iter_next = iter_reg - 4'd1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration writes must arrive only while idle (the user's duty, not enforced here); size change restarts
        if (cfg_we)
        begin
            unique case (cfg_index) inside
                rcem_pkg::REG_FRAME_WIDTH,
                rcem_pkg::REG_FRAME_HEIGHT:
                begin
                    if (cfg_index == rcem_pkg::REG_FRAME_WIDTH)
                        width_next = cfg_data;
                    else
                        height_next = cfg_data;
                    load_next = '0;
                    max_next  = '0;
                    x_next    = '0;
                    y_next    = '0;
                    idx_next  = '0;
                end
                rcem_pkg::REG_NORMALIZE:
                begin
                    norm_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            iter_reg      <= '0;
            sweep_reg     <= 1'b0;
            load_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            idx_reg       <= '0;
            max_reg       <= '0;
            width_reg     <= rcem_pkg::CFG_W'(256);
            height_reg    <= rcem_pkg::CFG_W'(256);
            norm_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            iter_reg      <= iter_next;
            sweep_reg     <= sweep_next;
            load_reg      <= load_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            idx_reg       <= idx_next;
            max_reg       <= max_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            norm_reg      <= norm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        s_reg    <= s_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        v_reg    <= v_next;
        root_reg <= root_next;
        rrem_reg <= rrem_next;
        edge_reg <= edge_next;
        last_reg <= last_next;
        nrdy_reg <= nrdy_next;
    end

    assign out_valid  = out_valid_reg;
    assign edge_value = edge_reg;
    assign last       = last_reg;
    assign not_ready  = nrdy_reg;

`ifndef SYNTHESIS
    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == ST_IDLE)
        else $error("frame memory written outside idle");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> phase_reg <= 3'd4)
        else $error("read phase out of range");

    a_max_clear_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !loaded) |-> max_reg == '0)
        else $error("frame maximum set before frame complete");

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && not_ready) |-> (edge_value == '0 && !last))
        else $error("not_ready result carries data");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT && iter_reg == 4'd0) |-> !out_valid_reg || out_ready)
        else $error("result overwrites a pending transfer");
`endif

endmodule

`default_nettype wire

### rtl/rcem_ram.sv
// ----------------------------------------------------------------------------
// rcem_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rcem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for roberts_cross_edge_magnitude_unit
// Loads frames of many sizes through the valid/ready input channel, drains
// edge magnitudes and checks every result against a bit exact predictor of
// the Roberts cross gradient, in raw and normalize mode, with random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Spare register index; the unit must ignore it.
    localparam logic [rcem_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [rcem_pkg::PIX_W-1:0] edge_value;
        logic                       last;
        logic                       not_ready;
    } edge_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           command;
    logic [rcem_pkg::PIX_W-1:0]     pixel;
    logic                           out_valid;
    logic                           out_ready;
    logic [rcem_pkg::PIX_W-1:0]     edge_value;
    logic                           last;
    logic                           not_ready;
    logic                           cfg_we;
    logic [rcem_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rcem_pkg::CFG_W-1:0]     cfg_data;

    roberts_cross_edge_magnitude_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .edge_value (edge_value),
        .last       (last),
        .not_ready  (not_ready),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the frame, counters and registers
    // ------------------------------------------------------------------
    logic [rcem_pkg::PIX_W-1:0] img [0:65535];
    int unsigned                loaded_n;
    int unsigned                drained_n;
    int unsigned                frame_peak;
    logic [rcem_pkg::CFG_W-1:0] width_reg;
    logic [rcem_pkg::CFG_W-1:0] height_reg;
    logic                       norm_reg;

    edge_result_t     pending_edges [$];
    int unsigned      errors;
    int unsigned      items_sent;
    int unsigned      tx_idle_pct;
    int unsigned      rx_idle_pct;
    int unsigned      hold_off;
    longint unsigned  cycles;

    // Clamp a size register the way the unit does: 0 acts as 1, above 256 as 256.
    function automatic int unsigned clamp_size(logic [rcem_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic int unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Square gradient of pixel (x,y), right and bottom neighbors held at the border.
    function automatic int unsigned grad_square(int unsigned x, int unsigned y,
                                                int unsigned w, int unsigned h);
        int unsigned x1;
        int unsigned y1;
        int          gx;
        int          gy;
        x1 = (x + 1 < w) ? x + 1 : w - 1;
        y1 = (y + 1 < h) ? y + 1 : h - 1;
        gx = int'(img[y * w + x]) - int'(img[y1 * w + x1]);
        gy = int'(img[y * w + x1]) - int'(img[y1 * w + x]);
        return gx * gx + gy * gy;
    endfunction

    function automatic void restart_frame();
        loaded_n   = 0;
        drained_n  = 0;
        frame_peak = 0;
    endfunction

    // Advance the predictor by one accepted transfer; queue the result it causes.
    function automatic void predict_edge(logic cmd, logic [rcem_pkg::PIX_W-1:0] pix);
        int unsigned     w;
        int unsigned     h;
        int unsigned     s;
        int unsigned     v;
        longint unsigned q;
        edge_result_t    r;
        w = clamp_size(width_reg);
        h = clamp_size(height_reg);
        if (cmd == rcem_pkg::CMD_LOAD) begin
            if (loaded_n < w * h) begin
                img[loaded_n] = pix;
                loaded_n++;
                if (loaded_n == w * h) begin
                    frame_peak = 0;
                    for (int unsigned y = 0; y < h; y++)
                        for (int unsigned x = 0; x < w; x++) begin
                            s = grad_square(x, y, w, h);
                            if (s > frame_peak) frame_peak = s;
                        end
                end
            end
            return;
        end
        if (loaded_n < w * h) begin
            r.edge_value = '0;
            r.last       = 1'b0;
            r.not_ready  = 1'b1;
            pending_edges.push_back(r);
            return;
        end
        s = grad_square(drained_n % w, drained_n / w, w, h);
        if (norm_reg) begin
            if (frame_peak != 0) begin
                q = (64'd65025 * s) / frame_peak;
                v = floor_sqrt(q);
            end else begin
                v = 0;
            end
        end else begin
            v = floor_sqrt(s);
        end
        if (v > 255) v = 255;
        r.edge_value = v[rcem_pkg::PIX_W-1:0];
        r.not_ready  = 1'b0;
        if (drained_n + 1 >= w * h) begin
            r.last = 1'b1;
            restart_frame();
        end else begin
            r.last = 1'b0;
            drained_n++;
        end
        pending_edges.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run; the limit is far above the slowest correct run.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: sample the handshake as seen before the edge, compare
    // with the oldest expectation, then pick the next ready level.
    // ------------------------------------------------------------------
    initial begin
        edge_result_t exp_r;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                if (pending_edges.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result edge=%0d last=%0d not_ready=%0d",
                             $time, edge_value, last, not_ready);
                end else begin
                    exp_r = pending_edges.pop_front();
                    if (edge_value !== exp_r.edge_value) begin
                        errors++;
                        $display("%0t: edge_value expected %0d actual %0d",
                                 $time, exp_r.edge_value, edge_value);
                    end
                    if (last !== exp_r.last) begin
                        errors++;
                        $display("%0t: last expected %0d actual %0d",
                                 $time, exp_r.last, last);
                    end
                    if (not_ready !== exp_r.not_ready) begin
                        errors++;
                        $display("%0t: not_ready expected %0d actual %0d",
                                 $time, exp_r.not_ready, not_ready);
                    end
                end
            end
            // A requested hold-off is counted down here, cycle by cycle.
            if (hold_off > 0) begin
                hold_off--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side helpers. Every task starts and ends just after a rising edge.
    // ------------------------------------------------------------------

    // Offer one transfer; possibly a random gap first, then hold valid until accepted.
    task automatic send_item(logic cmd, logic [rcem_pkg::PIX_W-1:0] pix);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        pixel    <= pix;
        do @(posedge clk); while (!in_ready);
        predict_edge(cmd, pix);
        items_sent++;
    endtask

    // Drop valid, wait for every expected result, then let a full frame
    // sweep run out, since the last load gives no result to wait on.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge clk);
        repeat (6 * clamp_size(width_reg) * clamp_size(height_reg) + 60) @(posedge clk);
    endtask

    // One write cycle, then cfg_we is dropped again before the next write.
    task automatic write_reg(logic [rcem_pkg::CFG_IDX_W-1:0] idx,
                             logic [rcem_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == rcem_pkg::REG_FRAME_WIDTH) begin
            width_reg = data;
            restart_frame();
        end else if (idx == rcem_pkg::REG_FRAME_HEIGHT) begin
            height_reg = data;
            restart_frame();
        end else if (idx == rcem_pkg::REG_NORMALIZE) begin
            norm_reg = data[0];
        end
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(logic [rcem_pkg::CFG_W-1:0] w, logic [rcem_pkg::CFG_W-1:0] h,
                             logic norm);
        settle();
        write_reg(rcem_pkg::REG_FRAME_WIDTH, w);
        write_reg(rcem_pkg::REG_FRAME_HEIGHT, h);
        write_reg(rcem_pkg::REG_NORMALIZE, {{(rcem_pkg::CFG_W-1){1'b0}}, norm});
    endtask

    // Load a full frame of random pixels and drain it. With noise, sprinkle
    // early drains and an extra load; noisy or not, sometimes flip normalize halfway through.
    task automatic run_frame(bit noisy);
        int unsigned n;
        n = clamp_size(width_reg) * clamp_size(height_reg);
        for (int unsigned i = 0; i < n; i++) begin
            if (noisy && $urandom_range(9) == 0) send_item(rcem_pkg::CMD_DRAIN, 8'h00);
            send_item(rcem_pkg::CMD_LOAD, 8'($urandom_range(255)));
        end
        if (noisy && $urandom_range(3) == 0)
            send_item(rcem_pkg::CMD_LOAD, 8'($urandom_range(255)));
        for (int unsigned i = 0; i < n; i++) begin
            if (i == n / 2 && n > 1 && $urandom_range(7) == 0) begin
                settle();
                write_reg(rcem_pkg::REG_NORMALIZE,
                          {{(rcem_pkg::CFG_W-1){1'b0}}, ~norm_reg});
            end
            send_item(rcem_pkg::CMD_DRAIN, 8'h00);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Early drain, extreme pixels, an extra load, zero maximum, normalize.
    task automatic test_directed();
        send_item(rcem_pkg::CMD_DRAIN, 8'h00);           // nothing loaded at all
        set_frame(9'd2, 9'd2, 1'b0);
        send_item(rcem_pkg::CMD_LOAD, 8'd0);
        send_item(rcem_pkg::CMD_LOAD, 8'd255);
        send_item(rcem_pkg::CMD_DRAIN, 8'h00);           // frame half loaded
        send_item(rcem_pkg::CMD_LOAD, 8'd255);
        send_item(rcem_pkg::CMD_LOAD, 8'd0);
        send_item(rcem_pkg::CMD_LOAD, 8'd77);            // frame full: ignored
        repeat (4) send_item(rcem_pkg::CMD_DRAIN, 8'h00);
        // Same pattern scaled by the frame maximum.
        set_frame(9'd2, 9'd2, 1'b1);
        send_item(rcem_pkg::CMD_LOAD, 8'd0);
        send_item(rcem_pkg::CMD_LOAD, 8'd255);
        send_item(rcem_pkg::CMD_LOAD, 8'd255);
        send_item(rcem_pkg::CMD_LOAD, 8'd0);
        repeat (4) send_item(rcem_pkg::CMD_DRAIN, 8'h00);
        // Flat frame: zero maximum gives zero in normalize mode.
        repeat (4) send_item(rcem_pkg::CMD_LOAD, 8'd128);
        repeat (4) send_item(rcem_pkg::CMD_DRAIN, 8'h00);
        settle();
        write_reg(REG_SPARE, 9'h1FF);
    endtask

    // Size extremes and a size write in the middle of a frame.
    task automatic test_sizes();
        set_frame(9'd0, 9'd0, 1'b0);           // acts as 1 x 1
        run_frame(0);
        // Width above the maximum acts as 256: the frame is not complete
        // one pixel short of that, then drain the first few magnitudes.
        set_frame(9'd511, 9'd1, 1'b1);
        for (int unsigned i = 0; i < 255; i++)
            send_item(rcem_pkg::CMD_LOAD, 8'($urandom_range(255)));
        send_item(rcem_pkg::CMD_DRAIN, 8'h00);
        send_item(rcem_pkg::CMD_LOAD, 8'($urandom_range(255)));
        repeat (4) send_item(rcem_pkg::CMD_DRAIN, 8'h00);
        set_frame(9'd4, 9'd4, 1'b0);           // restarts the partly drained frame
        repeat (5) send_item(rcem_pkg::CMD_LOAD, 8'($urandom_range(255)));
        settle();
        write_reg(rcem_pkg::REG_FRAME_WIDTH, 9'd3);      // restarts the frame
        run_frame(0);
        settle();
        write_reg(rcem_pkg::REG_FRAME_HEIGHT, 9'd2);
        run_frame(1);
    endtask

    // Random small frames, mostly well formed, until the item budget is spent.
    task automatic test_random(int unsigned budget);
        int unsigned stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            set_frame(9'($urandom_range(1, 6)), 9'($urandom_range(1, 6)),
                      1'($urandom_range(1)));
            run_frame($urandom_range(3) == 0);
        end
    endtask

    // Hold the receiver off long enough that drains back up and the input
    // stalls, then pause the sender until everything has come back.
    task automatic test_backpressure();
        set_frame(9'd3, 9'd3, 1'b1);
        hold_off = 600;
        run_frame(0);
        settle();
        run_frame(1);
    endtask

    initial begin
        in_valid    <= 1'b0;
        command     <= rcem_pkg::CMD_LOAD;
        pixel       <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= rcem_pkg::REG_FRAME_WIDTH;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        errors      = 0;
        items_sent  = 0;
        hold_off    = 0;
        tx_idle_pct = 18;
        rx_idle_pct = 81;
        width_reg   = 9'd256;
        height_reg  = 9'd256;
        norm_reg    = 1'b0;
        restart_frame();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_sizes();
        test_random(30);
        tx_idle_pct = 81;
        rx_idle_pct = 18;
        test_random(30);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(30);
        test_backpressure();

        // Drain everything still expected, then let the unit go quiet.
        in_valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/rcem_pkg.sv
rtl/rcem_ram.sv
rtl/roberts_cross_edge_magnitude_unit.sv
verif/tb.sv
